FILE: src/vln_pkg.sv
// Shared types and constants for the vector length and normalize block.
package vln_pkg;

    // Field widths.
    localparam int COMP_W     = 16;
    localparam int MAG_W      = 16;
    localparam int SQ_W       = 34;
    localparam int LEN_W      = 17;
    localparam int UNIT_FRAC  = 14;
    localparam int QUO_W      = UNIT_FRAC + 1;
    localparam int ROOT_REM_W = LEN_W + 2;
    localparam int DIV_REM_W  = LEN_W + 1;
    localparam int LANES      = 3;

    // Item travelling down the square-root chain.
    typedef struct packed {
        logic [SQ_W-1:0]                 sq;
        logic [SQ_W-1:0]                 rad;
        logic [ROOT_REM_W-1:0]           rem;
        logic [LEN_W-1:0]                root;
        logic [LANES-1:0][MAG_W-1:0]     mag;
        logic [LANES-1:0]                neg;
    } t_sqrt_data;

    // Item travelling down the divider chain.
    typedef struct packed {
        logic [SQ_W-1:0]                 sq;
        logic [LEN_W-1:0]                len;
        logic [LANES-1:0]                neg;
        logic [LANES-1:0][DIV_REM_W-1:0] rem;
        logic [LANES-1:0][QUO_W-1:0]     dvd;
        logic [LANES-1:0][QUO_W-1:0]     quo;
    } t_div_data;

endpackage

FILE: src/vln_sqrt_cell.sv
// One cell of the square-root chain: settles one bit of the root.
module vln_sqrt_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  vln_pkg::t_sqrt_data i_data,
    output logic                o_valid,
    output vln_pkg::t_sqrt_data o_data
);
    import vln_pkg::*;

    logic                  r_valid;
    t_sqrt_data            r_data;
    t_sqrt_data            n_data;
    logic [ROOT_REM_W-1:0] w_rem;
    logic [ROOT_REM_W-1:0] w_trial;

    // Bring down the next two radicand bits and try the next root bit.
    always_comb begin
        n_data  = i_data;
        w_rem   = {i_data.rem[ROOT_REM_W-3:0], i_data.rad[SQ_W-1:SQ_W-2]};
        w_trial = {i_data.root, 2'b01};
        n_data.rad = {i_data.rad[SQ_W-3:0], 2'b00};
        if (w_rem >= w_trial) begin
            n_data.rem  = w_rem - w_trial;
            n_data.root = {i_data.root[LEN_W-2:0], 1'b1};
        end else begin
            n_data.rem  = w_rem;
            n_data.root = {i_data.root[LEN_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
endmodule

FILE: src/vln_div_cell.sv
// One cell of the divider chain: settles one quotient bit in each lane.
module vln_div_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  vln_pkg::t_div_data i_data,
    output logic               o_valid,
    output vln_pkg::t_div_data o_data
);
    import vln_pkg::*;

    logic                 r_valid;
    t_div_data            r_data;
    t_div_data            n_data;
    logic [DIV_REM_W-1:0] w_part [LANES];
    logic [DIV_REM_W-1:0] w_len;

    // Shift in the next dividend bit and subtract the length where it fits.
    always_comb begin
        n_data = i_data;
        w_len  = {1'b0, i_data.len};
        for (int l = 0; l < LANES; l++) begin
            w_part[l] = {i_data.rem[l][DIV_REM_W-2:0], i_data.dvd[l][QUO_W-1]};
            n_data.dvd[l] = {i_data.dvd[l][QUO_W-2:0], 1'b0};
            if (w_part[l] >= w_len) begin
                n_data.rem[l] = w_part[l] - w_len;
                n_data.quo[l] = {i_data.quo[l][QUO_W-2:0], 1'b1};
            end else begin
                n_data.rem[l] = w_part[l];
                n_data.quo[l] = {i_data.quo[l][QUO_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
endmodule

FILE: src/vector_length_normalize.sv
// Top level: difference, squares, square-root chain, divider chain, output.
//
//  Channel  | Direction | tdata (lowest bit up)                          | tuser
//  s_axis   | in        | a_x a_y a_z b_x b_y b_z, 16 bits each          | -
//  m_axis   | out       | squared_length length unit_x unit_y unit_z     | zero_length
//
// One item is accepted per cycle while the output item is taken or absent.
// Pipeline: three front stages, 17 root cells, 15 divider cells and the output register.
// The whole pipeline moves as one and holds while the output item is not taken.
// Reset clears the valid bits only; payload registers are not reset.
module vector_length_normalize (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [95:0]  i_s_tdata,   // a_x, a_y, a_z, b_x, b_y, b_z
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [103:0] o_m_tdata,   // squared_length, length, unit_x, unit_y, unit_z, zeros
    output logic         o_m_tuser    // zero_length
);
    import vln_pkg::*;

    localparam int SQRT_CELLS = LEN_W;
    localparam int DIV_CELLS  = QUO_W;

    logic w_en;
    assign w_en       = !o_m_tvalid || i_m_tready;
    assign o_s_tready = w_en;

    // Stage 0: difference at one extra bit, split into sign and magnitude.
    logic                          r_v0;
    logic [LANES-1:0][MAG_W-1:0]   r_mag0;
    logic [LANES-1:0]              r_neg0;
    logic signed [COMP_W:0]        w_diff [LANES];

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            w_diff[l] = $signed({i_s_tdata[l*COMP_W+COMP_W-1], i_s_tdata[l*COMP_W +: COMP_W]})
                      - $signed({i_s_tdata[(l+LANES)*COMP_W+COMP_W-1],
                                 i_s_tdata[(l+LANES)*COMP_W +: COMP_W]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int l = 0; l < LANES; l++) begin
                r_neg0[l] <= w_diff[l][COMP_W];
                r_mag0[l] <= w_diff[l][COMP_W] ? MAG_W'(-w_diff[l]) : MAG_W'(w_diff[l]);
            end
        end
    end

    // Stage 1: one square per lane.
    logic                          r_v1;
    logic [LANES-1:0][2*MAG_W-1:0] r_sqr1;
    logic [LANES-1:0][MAG_W-1:0]   r_mag1;
    logic [LANES-1:0]              r_neg1;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int l = 0; l < LANES; l++) begin
                r_sqr1[l] <= r_mag0[l] * r_mag0[l];
            end
            r_mag1 <= r_mag0;
            r_neg1 <= r_neg0;
        end
    end

    // Stage 2: sum of squares.
    logic                          r_v2;
    logic [SQ_W-1:0]               r_sq2;
    logic [LANES-1:0][MAG_W-1:0]   r_mag2;
    logic [LANES-1:0]              r_neg2;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sq2  <= SQ_W'(r_sqr1[0]) + SQ_W'(r_sqr1[1]) + SQ_W'(r_sqr1[2]);
            r_mag2 <= r_mag1;
            r_neg2 <= r_neg1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (w_en) begin
            r_v0 <= i_s_tvalid;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
        end
    end

    // Square-root chain.
    logic       w_sv [SQRT_CELLS+1];
    t_sqrt_data w_sd [SQRT_CELLS+1];

    always_comb begin
        w_sv[0]      = r_v2;
        w_sd[0].sq   = r_sq2;
        w_sd[0].rad  = r_sq2;
        w_sd[0].rem  = '0;
        w_sd[0].root = '0;
        w_sd[0].mag  = r_mag2;
        w_sd[0].neg  = r_neg2;
    end

    for (genvar k = 0; k < SQRT_CELLS; k++) begin : g_sqrt
        vln_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_sv[k]),
            .i_data  (w_sd[k]),
            .o_valid (w_sv[k+1]),
            .o_data  (w_sd[k+1])
        );
    end

    // Divider chain; the top dividend bits start as the remainder.
    logic      w_dv [DIV_CELLS+1];
    t_div_data w_dd [DIV_CELLS+1];

    always_comb begin
        w_dv[0]     = w_sv[SQRT_CELLS];
        w_dd[0].sq  = w_sd[SQRT_CELLS].sq;
        w_dd[0].len = w_sd[SQRT_CELLS].root;
        w_dd[0].neg = w_sd[SQRT_CELLS].neg;
        for (int l = 0; l < LANES; l++) begin
            w_dd[0].rem[l] = DIV_REM_W'(w_sd[SQRT_CELLS].mag[l][MAG_W-1:1]);
            w_dd[0].dvd[l] = {w_sd[SQRT_CELLS].mag[l][0], {(QUO_W-1){1'b0}}};
            w_dd[0].quo[l] = '0;
        end
    end

    for (genvar k = 0; k < DIV_CELLS; k++) begin : g_div
        vln_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_dv[k]),
            .i_data  (w_dd[k]),
            .o_valid (w_dv[k+1]),
            .o_data  (w_dd[k+1])
        );
    end

    // Output register: apply signs and the zero-length case.
    logic                          r_ov;
    logic [SQ_W-1:0]               r_sq;
    logic [LEN_W-1:0]              r_len;
    logic [LANES-1:0][COMP_W-1:0]  r_unit;
    logic                          r_zero;
    logic [LANES-1:0][COMP_W-1:0]  n_unit;
    logic                          n_zero;
    t_div_data                     w_last;

    always_comb begin
        w_last = w_dd[DIV_CELLS];
        n_zero = (w_last.len == '0);
        for (int l = 0; l < LANES; l++) begin
            if (n_zero) begin
                n_unit[l] = '0;
            end else if (w_last.neg[l]) begin
                n_unit[l] = COMP_W'(-{1'b0, w_last.quo[l]});
            end else begin
                n_unit[l] = COMP_W'(w_last.quo[l]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_en) begin
            r_ov <= w_dv[DIV_CELLS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sq   <= w_last.sq;
            r_len  <= w_last.len;
            r_unit <= n_unit;
            r_zero <= n_zero;
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = {5'b0, r_unit[2], r_unit[1], r_unit[0], r_len, r_sq};
    assign o_m_tuser  = r_zero;

`ifndef SYNTHESIS
    // The zero flag marks exactly a zero length.
    a_zero_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> (r_zero == (r_len == '0)))
        else $error("zero flag does not match length");

    // A zero length gives zero components.
    a_zero_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_zero) |-> (r_unit == '0))
        else $error("nonzero unit with zero length");

    // The root never squares above the sum.
    a_root_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> ((SQ_W'(r_len) * SQ_W'(r_len)) <= r_sq))
        else $error("root too large");

    // A result moves on only when the pipeline is enabled.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !i_m_tready) |=> (r_ov && $stable(r_len)))
        else $error("output item changed while stalled");
`endif
endmodule

FILE: tb/sv/tb.sv
// Testbench for vector_length_normalize: directed table and random vectors checked by a predictor.
`timescale 1ns / 100ps

module tb;

    localparam int LATENCY = 36;

    // Expected result of one item.
    typedef struct packed {
        logic [33:0] sq;
        logic [16:0] len;
        logic [15:0] ux;
        logic [15:0] uy;
        logic [15:0] uz;
        logic        zl;
    } t_norm;

    // One directed row: the six components and whether a typed result applies.
    typedef struct {
        logic [15:0] c[6];
        bit          typed;
        t_norm       res;
    } t_row;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_tvalid = 1'b0;
    logic         o_s_tready;
    logic [95:0]  i_s_tdata = '0;   // a_x, a_y, a_z, b_x, b_y, b_z
    logic         o_m_tvalid;
    logic         i_m_tready = 1'b0;
    logic [103:0] o_m_tdata;        // squared_length, length, unit_x, unit_y, unit_z, zeros
    logic         o_m_tuser;        // zero_length

    t_norm pending_norms[$];
    int    errors = 0;
    int    send_idle = 0;     // idle percentage for the sender
    int    recv_stall = 0;    // stall percentage for the receiver
    bit    hold_off = 1'b0;   // long receiver hold-off request
    bit    stim_done = 1'b0;

    vector_length_normalize uut (.*);

    always #6 i_clk = ~i_clk;

    // Integer square root, truncated.
    function automatic logic [16:0] int_sqrt(input logic [33:0] n);
        logic [16:0] r;
        r = 0;
        for (int b = 16; b >= 0; b--) begin
            if ((({17'd0, r} | (34'd1 << b)) * ({17'd0, r} | (34'd1 << b))) <= n)
                r[b] = 1'b1;
        end
        return r;
    endfunction

    // Predicts the length and direction of a - b.
    function automatic t_norm predict_norm(input logic [95:0] d);
        logic signed [16:0] diff[3];
        logic [16:0]        mag[3];
        logic [15:0]        u[3];
        logic [33:0]        q;
        t_norm              r;
        r.sq = 0;
        for (int i = 0; i < 3; i++) begin
            diff[i] = $signed(d[16*i +: 16]) - $signed(d[16*(i+3) +: 16]);
            mag[i] = diff[i] < 0 ? -diff[i] : diff[i];
            r.sq += {17'd0, mag[i]} * {17'd0, mag[i]};
        end
        r.len = int_sqrt(r.sq);
        r.zl = (r.len == 0);
        for (int i = 0; i < 3; i++) begin
            if (r.zl) u[i] = 0;
            else begin
                q = ({17'd0, mag[i]} << 14) / {17'd0, r.len};
                u[i] = diff[i] < 0 ? -q[15:0] : q[15:0];
            end
        end
        r.ux = u[0];
        r.uy = u[1];
        r.uz = u[2];
        return r;
    endfunction

    // Offers one item and waits until it is taken; valid drops only while idling.
    task automatic send_vector(input logic [95:0] d);
        while ($urandom_range(99) < send_idle) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= d;
        pending_norms.push_back(predict_norm(d));
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    // Random component: extremes, small values or anything.
    function automatic logic [15:0] rand_comp();
        case ($urandom_range(5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'($signed($urandom_range(8)) - 4);
            default: return 16'($urandom);
        endcase
    endfunction

    // Receiver: stalls at random or for a long hold-off.
    always @(posedge i_clk) begin
        if (!i_rst_n) i_m_tready <= 1'b0;
        else i_m_tready <= !hold_off && ($urandom_range(99) >= recv_stall);
    end

    // Checker.
    always @(posedge i_clk) begin
        t_norm got, want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.sq  = o_m_tdata[33:0];
            got.len = o_m_tdata[50:34];
            got.ux  = o_m_tdata[66:51];
            got.uy  = o_m_tdata[82:67];
            got.uz  = o_m_tdata[98:83];
            got.zl  = o_m_tuser;
            if (pending_norms.size() == 0) begin
                $error("unexpected result");
                errors++;
            end else begin
                want = pending_norms.pop_front();
                if (got.sq != want.sq) begin
                    $error("squared_length exp %0d got %0d", want.sq, got.sq); errors++;
                end
                if (got.len != want.len) begin
                    $error("length exp %0d got %0d", want.len, got.len); errors++;
                end
                if (got.ux != want.ux) begin
                    $error("unit_x exp %0h got %0h", want.ux, got.ux); errors++;
                end
                if (got.uy != want.uy) begin
                    $error("unit_y exp %0h got %0h", want.uy, got.uy); errors++;
                end
                if (got.uz != want.uz) begin
                    $error("unit_z exp %0h got %0h", want.uz, got.uz); errors++;
                end
                if (got.zl != want.zl) begin
                    $error("zero_length exp %0d got %0d", want.zl, got.zl); errors++;
                end
            end
        end
    end

    // Long receiver hold-off while the sender keeps offering items.
    initial begin
        int n;
        wait (stim_done == 0 && i_rst_n);
        repeat (300) @(posedge i_clk);
        hold_off = 1'b1;
        n = 0;
        while (n < 200) begin
            @(posedge i_clk);
            n++;
        end
        hold_off = 1'b0;
    end

    // Run limit.
    initial begin
        #20ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Stimulus.
    initial begin
        t_row        rows[$];
        t_row        r;
        logic [95:0] d;
        t_norm       chk;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Zero length at the origin and with equal nonzero points, and single axes.
        r.c = '{0, 0, 0, 0, 0, 0}; r.typed = 1; r.res = '{0, 0, 0, 0, 0, 1};
        rows.push_back(r);
        r.c = '{16'h1234, 16'h8000, 16'h7fff, 16'h1234, 16'h8000, 16'h7fff};
        rows.push_back(r);
        r.c = '{16'h0100, 0, 0, 0, 0, 0}; r.res = '{34'h10000, 17'h100, 16'h4000, 0, 0, 0};
        rows.push_back(r);
        r.c = '{0, 0, 16'hff00, 0, 0, 0}; r.res = '{34'h10000, 17'h100, 0, 0, 16'hc000, 0};
        rows.push_back(r);
        r.typed = 0;
        r.c = '{16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h8000}; rows.push_back(r);
        r.c = '{16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff}; rows.push_back(r);
        r.c = '{16'h7fff, 0, 0, 16'h8000, 0, 0}; rows.push_back(r);
        r.c = '{1, 1, 1, 0, 0, 0}; rows.push_back(r);
        r.c = '{0, 16'hffff, 0, 0, 0, 0}; rows.push_back(r);
        r.c = '{16'h0300, 16'h0400, 0, 0, 0, 0}; rows.push_back(r);
        r.c = '{16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hfffe}; rows.push_back(r);

        foreach (rows[i]) begin
            d = {rows[i].c[5], rows[i].c[4], rows[i].c[3],
                 rows[i].c[2], rows[i].c[1], rows[i].c[0]};
            chk = predict_norm(d);
            if (rows[i].typed && chk != rows[i].res) begin
                $error("table row %0d disagrees with predictor", i);
                errors++;
            end
            send_vector(d);
        end

        // Random phases with different idling.
        for (int p = 0; p < 5; p++) begin
            case (p)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 88; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 88; end
                3: begin send_idle = 6;  recv_stall = 6;  end
                default: begin send_idle = 30; recv_stall = 30; end
            endcase
            for (int k = 0; k < 170; k++) begin
                for (int c = 0; c < 6; c++) d[16*c +: 16] = rand_comp();
                if ($urandom_range(15) == 0) d[95:48] = d[47:0];
                send_vector(d);
            end
        end
        i_s_tvalid <= 1'b0;
        stim_done = 1'b1;

        while (pending_norms.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (errors == 0 && pending_norms.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: filelist.f
src/vln_pkg.sv
src/vln_sqrt_cell.sv
src/vln_div_cell.sv
src/vector_length_normalize.sv
tb/sv/tb.sv
